// ===== design/dcs_pkg.sv =====
// shared constants, types and helper functions for the channel store
package dcs_pkg;

   localparam int UNIVERSES  = 2;
   localparam int SLOTS      = 8;
   localparam int CHANNELS   = 512;
   localparam int FULL_LEVEL = 255;

   localparam int MEM_DEPTH = UNIVERSES * CHANNELS;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int UIDX_W    = (UNIVERSES > 1) ? $clog2(UNIVERSES) : 1;
   localparam int SIDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [2:0] {
      KIND_CONNECT,
      KIND_DISCONNECT,
      KIND_DIM_READ,
      KIND_RAW_READ,
      KIND_WRITE,
      KIND_BLOCK,
      KIND_SET_LIVE,
      KIND_SET_DIMMER
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         universe;
      logic [9:0]         channel;
      logic [7:0]         value;
      logic signed [5:0]  slot;
      logic               live;
      logic               last;
   } item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       status;
      logic [4:0] granted_slot;
      logic       universe_live;
      logic [7:0] dimmer_level;
      logic       slot_changed;
   } result_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } mem_wr_type;

   // flat store address; zero when universe or channel is out of range
   function automatic logic [ADDR_W-1:0] chan_addr(input logic [7:0] universe,
                                                   input logic [9:0] channel);
      int a;
      a = 0;
      if ((int'(universe) < UNIVERSES) && (int'(channel) < CHANNELS)) begin
         a = int'(universe) * CHANNELS + int'(channel);
      end
      return ADDR_W'(a);
   endfunction

   // exact x / 255 for any x below 255*256, which covers every product of two bytes
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + 17'(x >> 8) + 17'd1;
      return t[15:8];
   endfunction

endpackage

// ===== design/dmx_channel_store_with_subscribers.sv =====
// top level of the lighting channel store with reader slots
//
//   channel | direction | tdata fields (lsb first)                      | tuser / tlast
//   req_    | in        | universe, channel, value, slot, live, pad    | tuser kind, tlast last
//   rsp_    | out       | data, status, granted_slot, universe_live,   | none
//           |           | dimmer_level, slot_changed                   |
//
// one transaction per cycle sustained while rsp_tready holds; a result passes the input stage
// and output stage; the store read is issued at acceptance, compared and written back from the
// input stage; after reset a clearing pass zeroes all UNIVERSES*CHANNELS (1024) store entries
// and no transaction is accepted meanwhile
// a stalled result holds the input stage; req_tready follows rsp_tready when both stages are full
module dmx_channel_store_with_subscribers (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // universe[7:0], channel[17:8], value[25:18], slot[31:26], live[32], zero[39:33]
   input  logic [dcs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind[2:0]
   input  logic [dcs_pkg::REQ_USER_W-1:0]    req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // data[7:0], status[8], granted_slot[13:9], universe_live[14], dimmer_level[22:15],
   // slot_changed[23]
   output logic [dcs_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   dcs_pkg::item_type   req_item;
   dcs_pkg::item_type   s1_item_ff, s1_item_in;
   logic                s1_valid_ff, s1_valid_in;
   dcs_pkg::result_type out_data_ff, out_data_in;
   logic                out_valid_ff, out_valid_in;
   dcs_pkg::result_type result;
   dcs_pkg::mem_wr_type mem_wr;
   logic [7:0]          stored;
   logic                clear_busy;
   logic                advance;
   logic                accept;

   always_comb begin
      req_item.kind     = dcs_pkg::kind_type'(req_tuser);
      req_item.universe = req_tdata[7:0];
      req_item.channel  = req_tdata[17:8];
      req_item.value    = req_tdata[25:18];
      req_item.slot     = $signed(req_tdata[31:26]);
      req_item.live     = req_tdata[32];
      req_item.last     = req_tlast;
   end

   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !clear_busy && (!s1_valid_ff || advance);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_item_in   = s1_item_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_item_in  = req_item;
      end
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      out_data_ff <= out_data_in;
   end

   dcs_chan_mem u_chan_mem (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (dcs_pkg::chan_addr(req_item.universe, req_item.channel)),
      .wr         (mem_wr),
      .rd_data    (stored),
      .clear_busy (clear_busy)
   );

   dcs_state u_state (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (s1_item_ff),
      .stored  (stored),
      .result  (result),
      .mem_wr  (mem_wr)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_data_ff.slot_changed, out_data_ff.dimmer_level,
                        out_data_ff.universe_live, out_data_ff.granted_slot,
                        out_data_ff.status, out_data_ff.data};

endmodule

// ===== design/dcs_chan_mem.sv =====
// channel byte memory with write-first read port and clearing sweep after reset
module dcs_chan_mem (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rd_en,
   input  logic [dcs_pkg::ADDR_W-1:0]        rd_addr,
   input  dcs_pkg::mem_wr_type               wr,
   output logic [7:0]                        rd_data,
   output logic                              clear_busy
);

   logic [7:0]                 chan_ram [dcs_pkg::MEM_DEPTH];
   logic [7:0]                 rd_data_ff;
   logic                       clr_busy_ff, clr_busy_in;
   logic [dcs_pkg::ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic                       we;
   logic [dcs_pkg::ADDR_W-1:0] wa;
   logic [7:0]                 wd;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + dcs_pkg::ADDR_W'(1);
         if (clr_cnt_ff == dcs_pkg::ADDR_W'(dcs_pkg::MEM_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      we = wr.en;
      wa = wr.addr;
      wd = wr.data;
      if (clr_busy_ff) begin
         we = 1'b1;
         wa = clr_cnt_ff;
         wd = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         chan_ram[wa] <= wd;
      end
   end

   // a write at the same edge as the read wins
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (we && (wa == rd_addr)) begin
            rd_data_ff <= wd;
         end else begin
            rd_data_ff <= chan_ram[rd_addr];
         end
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

// ===== design/dcs_state.sv =====
// universe flags, dimmers and reader slots, plus result and store-write logic
module dcs_state (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  dcs_pkg::item_type    item,
   input  logic [7:0]           stored,
   output dcs_pkg::result_type  result,
   output dcs_pkg::mem_wr_type  mem_wr
);

   logic                       live_ff   [dcs_pkg::UNIVERSES];
   logic [7:0]                 dimmer_ff [dcs_pkg::UNIVERSES];
   logic [dcs_pkg::SLOTS-1:0]  in_use_ff [dcs_pkg::UNIVERSES];
   logic [dcs_pkg::SLOTS-1:0]  newv_ff   [dcs_pkg::UNIVERSES];

   logic                       live_in;
   logic [7:0]                 dimmer_in;
   logic [dcs_pkg::SLOTS-1:0]  in_use_in;
   logic [dcs_pkg::SLOTS-1:0]  newv_in;

   logic                       uok, sok, cok;
   logic [dcs_pkg::UIDX_W-1:0] uidx;
   logic [dcs_pkg::SIDX_W-1:0] sidx;
   logic [dcs_pkg::SLOTS-1:0]  cur_use, cur_newv;
   logic                       found;
   logic [dcs_pkg::SIDX_W-1:0] free_idx;
   logic [15:0]                product;
   logic                       mark, wr_en, status;
   logic [7:0]                 data;
   logic [4:0]                 granted;

   assign uok      = item.universe < 8'(dcs_pkg::UNIVERSES);
   assign uidx     = item.universe[dcs_pkg::UIDX_W-1:0];
   assign sok      = !item.slot[5] && ($unsigned(item.slot) < 6'(dcs_pkg::SLOTS));
   assign sidx     = item.slot[dcs_pkg::SIDX_W-1:0];
   assign cok      = item.channel < 10'(dcs_pkg::CHANNELS);
   assign cur_use  = in_use_ff[uidx];
   assign cur_newv = newv_ff[uidx];
   assign product  = 16'(dimmer_ff[uidx]) * 16'(stored);

   // lowest free slot
   always_comb begin
      found    = 1'b0;
      free_idx = '0;
      for (int s = dcs_pkg::SLOTS - 1; s >= 0; s--) begin
         if (!cur_use[s]) begin
            found    = 1'b1;
            free_idx = dcs_pkg::SIDX_W'(s);
         end
      end
   end

   always_comb begin
      status    = 1'b0;
      data      = 8'd0;
      granted   = 5'd0;
      mark      = 1'b0;
      wr_en     = 1'b0;
      live_in   = live_ff[uidx];
      dimmer_in = dimmer_ff[uidx];
      in_use_in = cur_use;
      newv_in   = cur_newv;
      unique case (item.kind)
         dcs_pkg::KIND_CONNECT: begin
            if (found) begin
               in_use_in[free_idx] = 1'b1;
               granted             = 5'(free_idx);
            end else begin
               status = 1'b1;
            end
         end
         dcs_pkg::KIND_DISCONNECT: begin
            if (sok) begin
               in_use_in[sidx] = 1'b0;
            end else begin
               status = 1'b1;
            end
         end
         dcs_pkg::KIND_DIM_READ: begin
            if (sok) begin
               newv_in[sidx] = 1'b0;
            end
            if (!cok) begin
               status = 1'b1;
            end else if (live_ff[uidx]) begin
               data = dcs_pkg::div255(product);
            end
         end
         dcs_pkg::KIND_RAW_READ: begin
            if (!cok) begin
               status = 1'b1;
            end else begin
               data = stored;
            end
         end
         dcs_pkg::KIND_WRITE: begin
            if (!cok) begin
               status = 1'b1;
            end else if (stored != item.value) begin
               wr_en = 1'b1;
               mark  = 1'b1;
            end
         end
         dcs_pkg::KIND_BLOCK: begin
            wr_en = cok;
            mark  = item.last;
         end
         dcs_pkg::KIND_SET_LIVE: begin
            live_in = item.live;
            mark    = 1'b1;
         end
         dcs_pkg::KIND_SET_DIMMER: begin
            dimmer_in = item.value;
            mark      = 1'b1;
         end
         default: begin
            status = 1'b1;
         end
      endcase
      if (mark) begin
         newv_in = '1;
      end
   end

   always_comb begin
      result.data          = uok ? data : 8'd0;
      result.status        = uok ? status : 1'b1;
      result.granted_slot  = uok ? granted : 5'd0;
      result.universe_live = uok ? live_in : 1'b1;
      result.dimmer_level  = uok ? dimmer_in : 8'd0;
      result.slot_changed  = uok && sok && cur_newv[sidx];
      mem_wr.en            = advance && uok && wr_en;
      mem_wr.addr          = dcs_pkg::chan_addr(item.universe, item.channel);
      mem_wr.data          = item.value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int u = 0; u < dcs_pkg::UNIVERSES; u++) begin
            live_ff[u]   <= 1'b1;
            dimmer_ff[u] <= 8'(dcs_pkg::FULL_LEVEL);
            in_use_ff[u] <= '0;
            newv_ff[u]   <= '1;
         end
      end else if (advance && uok) begin
         live_ff[uidx]   <= live_in;
         dimmer_ff[uidx] <= dimmer_in;
         in_use_ff[uidx] <= in_use_in;
         newv_ff[uidx]   <= newv_in;
      end
   end

endmodule

// ===== design/dcs_checker.sv =====
// port-level checks on the channel store, bound to the top level
module dcs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [dcs_pkg::REQ_DATA_W-1:0]    req_tdata,
   input logic [dcs_pkg::REQ_USER_W-1:0]    req_tuser,
   input logic                              req_tlast,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [dcs_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   // a waiting result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed or dropped while stalled");

   // clearing pass blocks input right after reset
   assert property (@(posedge clock) reset |=> !req_tready)
      else $error("input ready during store clearing");

   // a failed transaction never grants a slot
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[13:9] == 5'd0)
      else $error("slot granted with error status");

   // read data only comes with ok status and no grant
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[7:0] != 8'd0) |-> !rsp_tdata[8] && (rsp_tdata[13:9] == 5'd0))
      else $error("nonzero data on a non-read result");

   // an accepted transaction into an empty output is followed, past the input stage, by a valid result on the output
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("result missing two cycles after acceptance");

endmodule

bind dmx_channel_store_with_subscribers dcs_checker u_dcs_checker (.*);
